FILE: design/rsst_pkg.sv
// ----------------------------------------------------------------------------
// rsst_pkg: shared definitions for the reference-counted slot table
// Sizes, the slot entry layout, result status codes and controller states.
// ----------------------------------------------------------------------------
package rsst_pkg;

	// Table geometry
	localparam int SLOT_COUNT = 64;
	localparam int COUNT_BITS = 16;
	localparam int IDX_BITS   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int SCAN_BITS  = $clog2(SLOT_COUNT + 1);

	// Fixed field widths of the request and result
	localparam int KEY_BITS     = 31;
	localparam int IN_KEY_BITS  = 32;
	localparam int OUT_IDX_BITS = 6;
	localparam int OUT_CNT_BITS = 16;

	localparam logic [COUNT_BITS-1:0] REF_MAX = '1;

	// Request operations
	typedef enum logic {
		OP_OPEN  = 1'b0,
		OP_CLOSE = 1'b1
	} op_t;

	// Result status codes
	typedef enum logic [2:0] {
		STS_ATTACHED  = 3'd0,
		STS_CREATED   = 3'd1,
		STS_DETACHED  = 3'd2,
		STS_FREED     = 3'd3,
		STS_BADKEY    = 3'd4,
		STS_FULL      = 3'd5,
		STS_NOTFOUND  = 3'd6,
		STS_SATURATED = 3'd7
	} status_t;

	// One slot as held in the table memory
	typedef struct packed {
		logic [KEY_BITS-1:0]   key;
		logic [COUNT_BITS-1:0] refs;
	} entry_t;

	// Controller states
	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_DONE
	} fsm_t;

endpackage

FILE: design/refcounted_shared_slot_table.sv
// ----------------------------------------------------------------------------
// refcounted_shared_slot_table: reference-counted key table
// Open and close requests against a table of keyed slots held in one
// synchronous memory, scanned one slot a cycle per request.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake             Payload
//  -------   -------------------   ---------------------------------------
//  request   in_valid / in_stall   operation, segment_key
//  result    out_valid / out_stall success, status, slot_index, ref_count
//
// A request with a valid key is scanned in order: one read per slot, a
// registered stage for the read data, a step to close the scan, then the
// write-back and the result load together. The next request is taken
// after that, once the controller is idle again. A bad key skips the scan
// and goes straight to loading its result, with no write-back.
// Reset clears the per-slot valid flags at once; no clearing pass is needed.
// One request is in work at a time; in_stall is high until it is finished.
// The result register holds while out_stall is high; a finished request
// waits for it before writing back.

module refcounted_shared_slot_table (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              operation,
	input  logic signed [rsst_pkg::IN_KEY_BITS-1:0] segment_key,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              success,
	output logic [2:0]                        status,
	output logic [rsst_pkg::OUT_IDX_BITS-1:0] slot_index,
	output logic [rsst_pkg::OUT_CNT_BITS-1:0] ref_count
);

	localparam int IB = rsst_pkg::IDX_BITS;
	localparam int CB = rsst_pkg::COUNT_BITS;
	localparam int SB = rsst_pkg::SCAN_BITS;
	localparam int KB = rsst_pkg::KEY_BITS;

	// Controller
	rsst_pkg::fsm_t fsm_q, fsm_d;
	logic           accept;
	logic           rd_issue;
	logic           commit;
	logic           out_free;
	logic           scan_end;

	// Request held during the scan
	logic          op_q;
	logic [KB-1:0] key_q;
	logic          bad_q;

	// Scan pointer and read stage
	logic [SB-1:0]       issue_q;
	logic [IB-1:0]       rd_addr;
	logic                rd_pend_s1;
	logic [IB-1:0]       rd_idx_s1;
	logic                rd_vld_s1;
	rsst_pkg::entry_t    rd_entry_s1;

	// Scan findings
	logic          hit_q;
	logic [IB-1:0] hit_idx_q;
	logic [CB-1:0] hit_refs_q;
	logic          free_q;
	logic [IB-1:0] free_idx_q;

	// Table storage
	rsst_pkg::entry_t        mem_q [rsst_pkg::SLOT_COUNT];
	logic [rsst_pkg::SLOT_COUNT-1:0] slot_vld_q;

	// Decision and write-back
	logic              wr_en;
	logic [IB-1:0]     wr_idx;
	rsst_pkg::entry_t  wr_entry;
	logic              vld_set;
	logic              vld_clr;
	logic              res_ok;
	rsst_pkg::status_t res_status;
	logic [IB-1:0]     res_idx;
	logic [CB-1:0]     res_cnt;
	logic [CB-1:0]     refs_inc;
	logic [CB-1:0]     refs_dec;

	// Result register
	logic                              out_valid_q;
	logic                              success_q;
	rsst_pkg::status_t                 status_q;
	logic [rsst_pkg::OUT_IDX_BITS-1:0] slot_index_q;
	logic [rsst_pkg::OUT_CNT_BITS-1:0] ref_count_q;

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign scan_end = (issue_q == SB'(rsst_pkg::SLOT_COUNT)) && !rd_pend_s1;
	assign rd_addr  = issue_q[IB-1:0];

	// Next state
	always_comb begin
		fsm_d = fsm_q;
		unique case (fsm_q)
			rsst_pkg::FSM_IDLE: begin
				if (accept) begin
					if (segment_key[rsst_pkg::IN_KEY_BITS-1] || segment_key == '0)
						fsm_d = rsst_pkg::FSM_DONE;
					else
						fsm_d = rsst_pkg::FSM_SCAN;
				end
			end
			rsst_pkg::FSM_SCAN: begin
				if (scan_end)
					fsm_d = rsst_pkg::FSM_DONE;
			end
			rsst_pkg::FSM_DONE: begin
				if (out_free)
					fsm_d = rsst_pkg::FSM_IDLE;
			end
			default: fsm_d = rsst_pkg::FSM_IDLE;
		endcase
	end

	// Controller outputs
	always_comb begin
		in_stall = 1'b1;
		rd_issue = 1'b0;
		commit   = 1'b0;
		unique case (fsm_q)
			rsst_pkg::FSM_IDLE: in_stall = 1'b0;
			rsst_pkg::FSM_SCAN: rd_issue = (issue_q != SB'(rsst_pkg::SLOT_COUNT));
			rsst_pkg::FSM_DONE: commit = out_free;
			default: in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fsm_q <= rsst_pkg::FSM_IDLE;
		else
			fsm_q <= fsm_d;
	end

	// Capture the request
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= operation;
			key_q <= segment_key[KB-1:0];
			bad_q <= segment_key[rsst_pkg::IN_KEY_BITS-1] || (segment_key == '0);
		end
	end

	// Advance the scan pointer and track reads in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q    <= '0;
			rd_pend_s1 <= 1'b0;
		end else begin
			if (accept)
				issue_q <= '0;
			else if (rd_issue)
				issue_q <= issue_q + SB'(1);
			rd_pend_s1 <= rd_issue;
		end
	end

	// Table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_idx] <= wr_entry;
	end

	always_ff @(posedge clk) begin
		rd_entry_s1 <= mem_q[rd_addr];
		rd_idx_s1   <= rd_addr;
	end

	// Slot valid flags: a slot without its flag is free, whatever its memory holds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_vld_q <= '0;
			rd_vld_s1  <= 1'b0;
		end else begin
			rd_vld_s1 <= slot_vld_q[rd_addr];
			if (vld_set)
				slot_vld_q[wr_idx] <= 1'b1;
			else if (vld_clr)
				slot_vld_q[wr_idx] <= 1'b0;
		end
	end

	// Record the matching slot and the lowest free slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (accept) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (rd_pend_s1) begin
			if (rd_vld_s1 && rd_entry_s1.key == key_q && !hit_q)
				hit_q <= 1'b1;
			if (!rd_vld_s1 && !free_q)
				free_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_pend_s1) begin
			if (rd_vld_s1 && rd_entry_s1.key == key_q && !hit_q) begin
				hit_idx_q  <= rd_idx_s1;
				hit_refs_q <= rd_entry_s1.refs;
			end
			if (!rd_vld_s1 && !free_q)
				free_idx_q <= rd_idx_s1;
		end
	end

	// Decide the result and the write-back
	assign refs_inc = hit_refs_q + CB'(1);
	assign refs_dec = hit_refs_q - CB'(1);

	always_comb begin
		wr_en      = 1'b0;
		wr_idx     = hit_idx_q;
		wr_entry   = '{key: key_q, refs: refs_inc};
		vld_set    = 1'b0;
		vld_clr    = 1'b0;
		res_ok     = 1'b0;
		res_status = rsst_pkg::STS_BADKEY;
		res_idx    = '0;
		res_cnt    = '0;
		if (bad_q) begin
			res_status = rsst_pkg::STS_BADKEY;
		end else if (op_q == rsst_pkg::OP_OPEN) begin
			if (hit_q) begin
				if (hit_refs_q == rsst_pkg::REF_MAX) begin
					res_status = rsst_pkg::STS_SATURATED;
				end else begin
					wr_en      = commit;
					res_ok     = 1'b1;
					res_status = rsst_pkg::STS_ATTACHED;
					res_idx    = hit_idx_q;
					res_cnt    = refs_inc;
				end
			end else if (free_q) begin
				wr_en      = commit;
				vld_set    = commit;
				wr_idx     = free_idx_q;
				wr_entry   = '{key: key_q, refs: CB'(1)};
				res_ok     = 1'b1;
				res_status = rsst_pkg::STS_CREATED;
				res_idx    = free_idx_q;
				res_cnt    = CB'(1);
			end else begin
				res_status = rsst_pkg::STS_FULL;
			end
		end else begin
			if (!hit_q) begin
				res_status = rsst_pkg::STS_NOTFOUND;
			end else if (hit_refs_q <= CB'(1)) begin
				vld_clr    = commit;
				res_ok     = 1'b1;
				res_status = rsst_pkg::STS_FREED;
				res_idx    = hit_idx_q;
			end else begin
				wr_en      = commit;
				wr_entry   = '{key: key_q, refs: refs_dec};
				res_ok     = 1'b1;
				res_status = rsst_pkg::STS_DETACHED;
				res_idx    = hit_idx_q;
				res_cnt    = refs_dec;
			end
		end
	end

	// Result register: load on commit, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (commit)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			success_q    <= res_ok;
			status_q     <= res_status;
			slot_index_q <= rsst_pkg::OUT_IDX_BITS'(res_idx);
			ref_count_q  <= rsst_pkg::OUT_CNT_BITS'(res_cnt);
		end
	end

	assign out_valid  = out_valid_q;
	assign success    = success_q;
	assign status     = status_q;
	assign slot_index = slot_index_q;
	assign ref_count  = ref_count_q;

endmodule

FILE: tb/refcounted_shared_slot_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refcounted_shared_slot_table_checker: result checker for the slot table
// Watches both channels, keeps its own copy of the slot table, works out the
// reply to every accepted request and compares each delivered result with it.
// ----------------------------------------------------------------------------
module refcounted_shared_slot_table_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic                                operation,
	input  logic [rsst_pkg::IN_KEY_BITS-1:0]    segment_key,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic                                success,
	input  logic [2:0]                          status,
	input  logic [rsst_pkg::OUT_IDX_BITS-1:0]   slot_index,
	input  logic [rsst_pkg::OUT_CNT_BITS-1:0]   ref_count,
	output int                                  mismatches,
	output int                                  pending,
	output int                                  checked,
	output logic [7:0]                          statuses_seen
);

	localparam int SHOWN_LIMIT = 10;
	localparam int SLOTS       = rsst_pkg::SLOT_COUNT;
	localparam int KB          = rsst_pkg::KEY_BITS;
	localparam int CB          = rsst_pkg::COUNT_BITS;
	localparam int IKB         = rsst_pkg::IN_KEY_BITS;
	localparam int OIB         = rsst_pkg::OUT_IDX_BITS;
	localparam int OCB         = rsst_pkg::OUT_CNT_BITS;

	typedef struct packed {
		logic              success;
		rsst_pkg::status_t status;
		logic [OIB-1:0]    slot;
		logic [OCB-1:0]    count;
	} slot_reply_t;

	// Shadow table: key 0 marks a free slot
	logic [KB-1:0] held_key  [SLOTS];
	logic [CB-1:0] held_refs [SLOTS];
	slot_reply_t   replies_due [$];

	// Apply one request to the shadow table and return the reply it earns
	function automatic slot_reply_t apply_request(input rsst_pkg::op_t op,
			input logic [IKB-1:0] key);
		slot_reply_t reply;
		int i;
		int hit;
		int vacant;
		reply.success = 1'b0;
		reply.status  = rsst_pkg::STS_BADKEY;
		reply.slot    = '0;
		reply.count   = '0;
		hit    = -1;
		vacant = -1;
		// reject zero and negative keys, table untouched
		if (key == '0 || key[IKB-1])
			return reply;
		for (i = 0; i < SLOTS; i++) begin
			if (hit < 0 && held_key[i] == key[KB-1:0])
				hit = i;
			if (vacant < 0 && held_key[i] == '0)
				vacant = i;
		end
		if (op == rsst_pkg::OP_OPEN) begin
			if (hit >= 0 && held_refs[hit] == rsst_pkg::REF_MAX) begin
				reply.status = rsst_pkg::STS_SATURATED;
			end else if (hit >= 0) begin
				held_refs[hit] = held_refs[hit] + 1'b1;
				reply.success  = 1'b1;
				reply.status   = rsst_pkg::STS_ATTACHED;
				reply.slot     = OIB'(hit);
				reply.count    = OCB'(held_refs[hit]);
			end else if (vacant >= 0) begin
				// claim the lowest free slot
				held_key[vacant]  = key[KB-1:0];
				held_refs[vacant] = CB'(1);
				reply.success     = 1'b1;
				reply.status      = rsst_pkg::STS_CREATED;
				reply.slot        = OIB'(vacant);
				reply.count       = OCB'(1);
			end else begin
				reply.status = rsst_pkg::STS_FULL;
			end
		end else begin
			if (hit < 0) begin
				reply.status = rsst_pkg::STS_NOTFOUND;
			end else if (held_refs[hit] <= 1) begin
				// last reference gone: free the slot
				held_key[hit]  = '0;
				held_refs[hit] = '0;
				reply.success  = 1'b1;
				reply.status   = rsst_pkg::STS_FREED;
				reply.slot     = OIB'(hit);
			end else begin
				held_refs[hit] = held_refs[hit] - 1'b1;
				reply.success  = 1'b1;
				reply.status   = rsst_pkg::STS_DETACHED;
				reply.slot     = OIB'(hit);
				reply.count    = OCB'(held_refs[hit]);
			end
		end
		return reply;
	endfunction

	// Predict on every accepted request, compare on every accepted result
	always @(posedge clk or negedge arst_n) begin : track
		slot_reply_t want;
		int i;
		if (!arst_n) begin
			for (i = 0; i < SLOTS; i++) begin
				held_key[i]  = '0;
				held_refs[i] = '0;
			end
			replies_due.delete();
			mismatches    = 0;
			checked       = 0;
			statuses_seen = '0;
			pending      <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				want = apply_request(rsst_pkg::op_t'(operation), segment_key);
				statuses_seen[want.status] = 1'b1;
				replies_due.push_back(want);
			end
			if (out_valid && !out_stall) begin
				if (replies_due.size() == 0) begin
					mismatches++;
					if (mismatches <= SHOWN_LIMIT)
						$display("%0t: result with no request waiting: %s%0b %0d %0d %0d",
							$realtime, "ok/status/slot/count ",
							success, status, slot_index, ref_count);
				end else begin
					want = replies_due.pop_front();
					checked++;
					if (success !== want.success || status !== want.status
							|| slot_index !== want.slot || ref_count !== want.count) begin
						mismatches++;
						if (mismatches <= SHOWN_LIMIT) begin
							$display("%0t: result %0d expected ok=%0b status=%0d slot=%0d count=%0d",
								$realtime, checked, want.success, want.status,
								want.slot, want.count);
							$display("%0t: result %0d actual   ok=%0b status=%0d slot=%0d count=%0d",
								$realtime, checked, success, status,
								slot_index, ref_count);
						end
					end
				end
			end
			pending <= replies_due.size();
		end
	end

endmodule

FILE: tb/refcounted_shared_slot_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refcounted_shared_slot_table_tb: testbench top for the slot table
// Drives open and close requests with random gaps, stalls the result side at
// random and once for a long stretch, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module refcounted_shared_slot_table_tb;

	localparam int RANDOM_REQUESTS = 1950;
	localparam int KEY_POOL        = 96;
	localparam int PHASE_LEN       = 160;
	localparam int MAX_WAIT        = 18;
	localparam int HOLD_AFTER      = 400;
	localparam int HOLD_CYCLES     = 400;
	localparam int SETTLE_CYCLES   = 80;
	localparam int RUN_LIMIT_NS    = 16_000_000;
	localparam int IKB             = rsst_pkg::IN_KEY_BITS;

	logic                              clk         = 1'b0;
	logic                              arst_n      = 1'b0;
	logic                              in_valid    = 1'b0;
	logic                              in_stall;
	logic                              operation   = 1'b0;
	logic [IKB-1:0]                    segment_key = '0;
	logic                              out_valid;
	logic                              out_stall   = 1'b0;
	logic                              success;
	logic [2:0]                        status;
	logic [rsst_pkg::OUT_IDX_BITS-1:0] slot_index;
	logic [rsst_pkg::OUT_CNT_BITS-1:0] ref_count;

	logic hold_off = 1'b0;
	bit   quiet    = 1'b0;
	int   requests_sent = 0;

	int          mismatches;
	int          pending;
	int          checked;
	logic [7:0]  statuses_seen;

	refcounted_shared_slot_table uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.operation   (operation),
		.segment_key (segment_key),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.success     (success),
		.status      (status),
		.slot_index  (slot_index),
		.ref_count   (ref_count)
	);

	refcounted_shared_slot_table_checker table_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.operation     (operation),
		.segment_key   (segment_key),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.success       (success),
		.status        (status),
		.slot_index    (slot_index),
		.ref_count     (ref_count),
		.mismatches    (mismatches),
		.pending       (pending),
		.checked       (checked),
		.statuses_seen (statuses_seen)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Hold reset from the start, release it on a falling edge away from the rising edge
	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Idle cycles for one request or result; none during quiet stretches
	function automatic int draw_wait();
		return quiet ? 0 : int'($urandom_range(0, MAX_WAIT));
	endfunction

	// Offer one request after a random gap and hold it until accepted
	task automatic send_request(input rsst_pkg::op_t op, input logic [IKB-1:0] key);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		operation   <= op;
		segment_key <= key;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		requests_sent++;
	endtask

	// Request stimulus and final verdict
	initial begin : request_source
		logic [IKB-1:0] key_pool [KEY_POOL];
		logic [IKB-1:0] key;
		rsst_pkg::op_t  op;
		int  n;
		int  roll;
		int  open_pct;

		for (n = 0; n < KEY_POOL; n++) begin
			key_pool[n] = $urandom() & 32'h7FFF_FFFF;
			if (key_pool[n] == '0)
				key_pool[n] = 32'd1;
		end
		open_pct = 90;

		wait (arst_n === 1'b1);
		@(posedge clk);

		// Directed: zero and negative bad keys, create, attach, detach, free,
		// slot reuse and close of an unknown key. Count saturation needs
		// 65535 opens of one key and is beyond the length of this run.
		send_request(rsst_pkg::OP_CLOSE, 32'd5);
		send_request(rsst_pkg::OP_OPEN,  32'd0);
		send_request(rsst_pkg::OP_CLOSE, 32'd0);
		send_request(rsst_pkg::OP_OPEN,  32'h8000_0000);
		send_request(rsst_pkg::OP_CLOSE, 32'hFFFF_FFFF);
		send_request(rsst_pkg::OP_OPEN,  32'd1);
		send_request(rsst_pkg::OP_OPEN,  32'h7FFF_FFFF);
		send_request(rsst_pkg::OP_OPEN,  32'd1);
		send_request(rsst_pkg::OP_OPEN,  32'd1);
		send_request(rsst_pkg::OP_CLOSE, 32'd1);
		send_request(rsst_pkg::OP_CLOSE, 32'h7FFF_FFFF);
		send_request(rsst_pkg::OP_OPEN,  32'h2AAA_AAAA);
		send_request(rsst_pkg::OP_OPEN,  32'h5555_5555);
		send_request(rsst_pkg::OP_CLOSE, 32'd1);
		send_request(rsst_pkg::OP_CLOSE, 32'd1);
		send_request(rsst_pkg::OP_CLOSE, 32'd1);
		send_request(rsst_pkg::OP_OPEN,  32'h5555_5555);
		send_request(rsst_pkg::OP_OPEN,  32'd1);
		send_request(rsst_pkg::OP_CLOSE, 32'h2AAA_AAAA);
		send_request(rsst_pkg::OP_CLOSE, 32'h5555_5555);
		send_request(rsst_pkg::OP_CLOSE, 32'h5555_5555);
		send_request(rsst_pkg::OP_CLOSE, 32'd1);

		// Random: phases that fill, churn and drain the table from a key
		// pool larger than the table, with a little noise mixed in
		for (n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n % PHASE_LEN == 0) begin
				case ((n / PHASE_LEN) % 3)
					0: open_pct = 90;
					1: open_pct = 55;
					default: open_pct = 25;
				endcase
				quiet = ($urandom_range(0, 3) == 0);
			end
			roll = $urandom_range(0, 99);
			if (roll < 2)
				key = '0;
			else if (roll < 5)
				key = $urandom() | 32'h8000_0000;
			else if (roll < 8)
				key = $urandom();
			else
				key = key_pool[$urandom_range(0, KEY_POOL - 1)];
			op = ($urandom_range(0, 99) < open_pct) ? rsst_pkg::OP_OPEN
				: rsst_pkg::OP_CLOSE;
			send_request(op, key);
		end
		in_valid <= 1'b0;

		// Drain outstanding results, then watch for strays
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Run covered %0d requests, %0d results checked, %0d mismatches",
			requests_sent, checked, mismatches);
		$display("Status codes reached (one bit per code, code 0 rightmost): %b",
			statuses_seen);
		if (mismatches == 0 && pending == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Result side: stall each result for a random number of offered cycles
	initial begin : result_sink
		int stall_left;
		stall_left = draw_wait();
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				stall_left = draw_wait();
			else if (out_valid && stall_left > 0)
				stall_left--;
			out_stall <= hold_off || (stall_left > 0);
		end
	end

	// Long hold-off on results while requests keep coming, to back up the block
	initial begin : result_hold
		wait (requests_sent >= HOLD_AFTER);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// Give up on a hung run
	initial begin : watchdog
		#RUN_LIMIT_NS;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
